// File: sv/assert_macros.svh
// Assertion helpers, clocked on clk and held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/gdd_pkg.sv
package gdd_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int NUM_W  = 23;
  localparam int OFF_W  = 9;
  localparam int CENT_W = 8;
  localparam int DIST_W = 22;

  localparam logic [DIST_W-1:0] DIST_MAX    = '1;
  localparam logic [OFF_W-1:0]  DAYS_COMMON = 9'd365;
  localparam logic [10:0]       RECIP_25    = 11'd1311;
  localparam int                RECIP_SHIFT = 15;
  localparam logic [MON_W-1:0]  MONTH_FEB   = 4'd2;
  localparam logic [MON_W-1:0]  MONTH_DEC   = 4'd12;

  typedef struct packed {
    logic [DAY_W-1:0]  first_day;
    logic [MON_W-1:0]  first_month;
    logic [YEAR_W-1:0] first_year;
    logic [DAY_W-1:0]  second_day;
    logic [MON_W-1:0]  second_month;
    logic [YEAR_W-1:0] second_year;
  } req_t;

  typedef struct packed {
    logic [DIST_W-1:0] day_distance;
    logic              range_error;
  } rsp_t;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
  } date_t;

  typedef struct packed {
    logic [NUM_W-1:0] base;
    logic [OFF_W-1:0] offset;
    logic             bad;
  } lane_out_t;

  typedef struct packed {
    logic lane_a;
    logic lane_b;
    logic merge_a;
    logic merge_b;
  } pipe_en_t;

  function automatic logic [OFF_W-1:0] days_before(input logic [MON_W-1:0] m);
    logic [OFF_W-1:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // floor(q / 25) for q < 4096 by reciprocal multiply
  function automatic logic [CENT_W-1:0] div25(input logic [YEAR_W-3:0] q);
    logic [NUM_W-1:0] prod;
    prod = NUM_W'(q) * NUM_W'(RECIP_25);
    return prod[RECIP_SHIFT +: CENT_W];
  endfunction

endpackage

// File: sv/gdd_lane.sv
module gdd_lane (
  input  logic              clk,
  input  gdd_pkg::pipe_en_t en,
  input  gdd_pkg::date_t    date,
  output gdd_pkg::lane_out_t res
);

  logic [gdd_pkg::YEAR_W-1:0] p;
  logic [gdd_pkg::CENT_W-1:0] p_cent;
  logic [gdd_pkg::CENT_W-1:0] y_cent;
  logic                       bad;

  logic [gdd_pkg::YEAR_W-1:0] a_p;
  logic [gdd_pkg::CENT_W-1:0] a_pc;
  logic [gdd_pkg::CENT_W-1:0] a_yc;
  logic [gdd_pkg::YEAR_W-1:0] a_year;
  logic [gdd_pkg::MON_W-1:0]  a_month;
  logic [gdd_pkg::DAY_W-1:0]  a_day;
  logic                       a_bad;

  logic [gdd_pkg::NUM_W-1:0]  base;
  logic [gdd_pkg::OFF_W-1:0]  offset;
  logic                       div100;
  logic                       leap;

  assign p      = date.year - 14'd1;
  assign p_cent = gdd_pkg::div25(p[gdd_pkg::YEAR_W-1:2]);
  assign y_cent = gdd_pkg::div25(date.year[gdd_pkg::YEAR_W-1:2]);
  assign bad    = (date.day == '0) || (date.month == '0) ||
                  (date.month > gdd_pkg::MONTH_DEC) || (date.year == '0);

  always_ff @(posedge clk) begin
    if (en.lane_a) begin
      a_p     <= p;
      a_pc    <= p_cent;
      a_yc    <= y_cent;
      a_year  <= date.year;
      a_month <= date.month;
      a_day   <= date.day;
      a_bad   <= bad;
    end
  end

  // whole years: 365p + p/4 - p/100 + p/400
  assign base = gdd_pkg::NUM_W'(a_p) * gdd_pkg::NUM_W'(gdd_pkg::DAYS_COMMON)
              + gdd_pkg::NUM_W'(a_p[gdd_pkg::YEAR_W-1:2])
              - gdd_pkg::NUM_W'(a_pc)
              + gdd_pkg::NUM_W'(a_pc[gdd_pkg::CENT_W-1:2]);

  assign div100 = (a_year[1:0] == 2'b00) &&
                  ((12'(a_yc) * 12'd25) == a_year[gdd_pkg::YEAR_W-1:2]);
  assign leap   = ((a_year[1:0] == 2'b00) && !div100) ||
                  (div100 && (a_yc[1:0] == 2'b00));

  assign offset = gdd_pkg::days_before(a_month)
                + gdd_pkg::OFF_W'(leap && (a_month > gdd_pkg::MONTH_FEB))
                + gdd_pkg::OFF_W'(a_day);

  always_ff @(posedge clk) begin
    if (en.lane_b) begin
      res.base   <= base;
      res.offset <= offset;
      res.bad    <= a_bad;
    end
  end

endmodule

// File: sv/gdd_merge.sv
module gdd_merge (
  input  logic               clk,
  input  gdd_pkg::pipe_en_t  en,
  input  gdd_pkg::lane_out_t lane_1,
  input  gdd_pkg::lane_out_t lane_2,
  output gdd_pkg::rsp_t      rsp
);

  logic [gdd_pkg::NUM_W-1:0]  c_n1;
  logic [gdd_pkg::NUM_W-1:0]  c_n2;
  logic                       c_err;

  logic [gdd_pkg::NUM_W-1:0]  d12;
  logic [gdd_pkg::NUM_W-1:0]  d21;
  logic [gdd_pkg::NUM_W-1:0]  mag;
  logic [gdd_pkg::DIST_W-1:0] sat;

  always_ff @(posedge clk) begin
    if (en.merge_a) begin
      c_n1  <= lane_1.base + gdd_pkg::NUM_W'(lane_1.offset);
      c_n2  <= lane_2.base + gdd_pkg::NUM_W'(lane_2.offset);
      c_err <= lane_1.bad || lane_2.bad;
    end
  end

  assign d12 = c_n1 - c_n2;
  assign d21 = c_n2 - c_n1;
  assign mag = (c_n1 >= c_n2) ? d12 : d21;
  assign sat = (mag > gdd_pkg::NUM_W'(gdd_pkg::DIST_MAX)) ? gdd_pkg::DIST_MAX
                                                          : mag[gdd_pkg::DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (en.merge_b) begin
      rsp.day_distance <= c_err ? '0 : sat;
      rsp.range_error  <= c_err;
    end
  end

endmodule

// File: sv/gregorian_date_difference.sv
// Days between two Gregorian dates.
//
// req channel: one beat carries both dates (day, month, year each).
// rsp channel: one beat per request with the absolute day count and
// range_error, which is set (and the count zero) when any day, month or
// year is zero or a month exceeds 12. The count saturates at 22 bits.
//
// Four register stages: two in each date lane (year-count divides, then
// the day-number sums) and two in the merge (day numbers, then the
// absolute difference into the output register). A req beat moves through
// the lane_a, lane_b, merge_a and merge_b registers in turn, rsp_valid with
// the last; one request is taken every cycle unless a stalled rsp backs up.
//
// Each stage holds its own valid bit and loads whenever it is empty or
// its successor moves, so a stalled rsp only backs up the pipeline as it
// fills; req_ready drops once all four stages hold a beat.
// rst clears the valid bits and drops any beats in flight; req_ready is
// high from the first cycle after reset.
`include "assert_macros.svh"

module gregorian_date_difference (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  gdd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output gdd_pkg::rsp_t rsp
);

  logic [3:0]         v;
  logic [3:0]         rdy;
  gdd_pkg::pipe_en_t  en;
  gdd_pkg::date_t     date_1;
  gdd_pkg::date_t     date_2;
  gdd_pkg::lane_out_t lane_1;
  gdd_pkg::lane_out_t lane_2;

  assign rdy[3] = !v[3] || rsp_ready;
  assign rdy[2] = !v[2] || rdy[3];
  assign rdy[1] = !v[1] || rdy[2];
  assign rdy[0] = !v[0] || rdy[1];

  assign en.lane_a  = rdy[0];
  assign en.lane_b  = rdy[1];
  assign en.merge_a = rdy[2];
  assign en.merge_b = rdy[3];

  assign req_ready = rdy[0];
  assign rsp_valid = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= req_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
    end
  end

  assign date_1.day   = req.first_day;
  assign date_1.month = req.first_month;
  assign date_1.year  = req.first_year;
  assign date_2.day   = req.second_day;
  assign date_2.month = req.second_month;
  assign date_2.year  = req.second_year;

  gdd_lane u_lane_1 (
    .clk  (clk),
    .en   (en),
    .date (date_1),
    .res  (lane_1)
  );

  gdd_lane u_lane_2 (
    .clk  (clk),
    .en   (en),
    .date (date_2),
    .res  (lane_2)
  );

  gdd_merge u_merge (
    .clk    (clk),
    .en     (en),
    .lane_1 (lane_1),
    .lane_2 (lane_2),
    .rsp    (rsp)
  );

  `ASSERT_IMPLIES(a_err_zero, rsp_valid && rsp.range_error, rsp.day_distance == '0)
  `ASSERT_IMPLIES(a_full_stall, (v == 4'hF) && !rsp_ready, !req_ready)
  `ASSERT_IMPLIES(a_empty_ready, !v[0], req_ready)
  `ASSERT_NEXT(a_out_source, !v[3] && !v[2], !rsp_valid)

endmodule

// File: tb/gregorian_date_difference_test.sv
module gregorian_date_difference_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 830;
  localparam int unsigned DRAIN_EVERY = 280;
  localparam int unsigned YEAR_TOP = (1 << gdd_pkg::YEAR_W) - 1;

  localparam int unsigned DAYS_BEFORE [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                               304, 334};
  localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    gdd_pkg::req_t data;
    bit            wait_drain;
  } pending_t;

  logic          clk;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  gdd_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  gdd_pkg::rsp_t rsp;

  pending_t      pending_dates[$];
  gdd_pkg::rsp_t expected_distances[$];
  pending_t      next_item;
  gdd_pkg::rsp_t expected_beat;
  bit            req_fire = 1'b0;
  int unsigned   gap_left = 0;
  int unsigned   stall_left = 0;
  int unsigned   calm_left = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   accepted_count = 0;
  int unsigned   total_items = 0;
  int unsigned   mismatch_count = 0;

  gregorian_date_difference dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  function automatic bit has_leap_day(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic bit bad_date(int unsigned d, int unsigned m, int unsigned y);
    return d == 0 || m == 0 || m > 12 || y == 0;
  endfunction

  function automatic int unsigned day_count(int unsigned d, int unsigned m, int unsigned y);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400 + DAYS_BEFORE[m - 1] + d;
    if (m > 2 && has_leap_day(y)) n++;
    return n;
  endfunction

  function automatic gdd_pkg::rsp_t predict_distance(gdd_pkg::req_t r);
    gdd_pkg::rsp_t res;
    int unsigned   a;
    int unsigned   b;
    int unsigned   span;
    res = '0;
    if (bad_date(r.first_day, r.first_month, r.first_year) ||
        bad_date(r.second_day, r.second_month, r.second_year)) begin
      res.range_error = 1'b1;
      return res;
    end
    a = day_count(r.first_day, r.first_month, r.first_year);
    b = day_count(r.second_day, r.second_month, r.second_year);
    span = (a >= b) ? a - b : b - a;
    res.day_distance = (span > gdd_pkg::DIST_MAX) ? gdd_pkg::DIST_MAX
                                                  : span[gdd_pkg::DIST_W-1:0];
    return res;
  endfunction

  function automatic gdd_pkg::req_t make_pair(int unsigned d1, int unsigned m1, int unsigned y1,
                                              int unsigned d2, int unsigned m2, int unsigned y2);
    gdd_pkg::req_t r;
    r.first_day    = gdd_pkg::DAY_W'(d1);
    r.first_month  = gdd_pkg::MON_W'(m1);
    r.first_year   = gdd_pkg::YEAR_W'(y1);
    r.second_day   = gdd_pkg::DAY_W'(d2);
    r.second_month = gdd_pkg::MON_W'(m2);
    r.second_year  = gdd_pkg::YEAR_W'(y2);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned random_year();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 13) return $urandom_range(1, 9999);
    if (r < 16) return $urandom_range(1, YEAR_TOP);
    if (r < 18) return $urandom_range(1, 8);
    if ($urandom_range(0, 1) == 0) return $urandom_range(9996, 10004);
    return $urandom_range(YEAR_TOP - 7, YEAR_TOP);
  endfunction

  function automatic gdd_pkg::date_t random_date(int unsigned y);
    gdd_pkg::date_t dt;
    int unsigned    len;
    dt.year  = gdd_pkg::YEAR_W'(y);
    dt.month = gdd_pkg::MON_W'($urandom_range(1, 12));
    len = MONTH_LEN[dt.month - 4'd1] +
          ((dt.month == gdd_pkg::MONTH_FEB && has_leap_day(y)) ? 1 : 0);
    dt.day = gdd_pkg::DAY_W'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 31)
                                                         : $urandom_range(1, len));
    return dt;
  endfunction

  function automatic gdd_pkg::req_t random_pair();
    gdd_pkg::req_t  r;
    gdd_pkg::date_t a;
    gdd_pkg::date_t b;
    int unsigned    mode;
    int             y2;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      return make_pair($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, YEAR_TOP),
                       $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, YEAR_TOP));
    end
    a = random_date(random_year());
    if ($urandom_range(0, 2) == 0) begin
      y2 = int'(a.year) + int'($urandom_range(0, 4)) - 2;
      if (y2 < 1) y2 = 1;
      if (y2 > int'(YEAR_TOP)) y2 = int'(YEAR_TOP);
    end else begin
      y2 = int'(random_year());
    end
    b = random_date(y2);
    r = make_pair(a.day, a.month, a.year, b.day, b.month, b.year);
    if (mode == 2) begin
      case ($urandom_range(0, 7))
        0: r.first_day = '0;
        1: r.first_month = '0;
        2: r.first_month = gdd_pkg::MON_W'($urandom_range(gdd_pkg::MONTH_DEC + 1, 15));
        3: r.first_year = '0;
        4: r.second_day = '0;
        5: r.second_month = '0;
        6: r.second_month = gdd_pkg::MON_W'($urandom_range(gdd_pkg::MONTH_DEC + 1, 15));
        default: r.second_year = '0;
      endcase
    end
    return r;
  endfunction

  task automatic queue_pair(gdd_pkg::req_t r, bit wait_drain);
    pending_t p;
    p.data = r;
    p.wait_drain = wait_drain;
    pending_dates.push_back(p);
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sender
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (gap_left != 0) begin
        req_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_dates.size() != 0 &&
                   !(pending_dates[0].wait_drain && expected_distances.size() != 0)) begin
        next_item = pending_dates.pop_front();
        req <= next_item.data;
        req_valid <= 1'b1;
        gap_left <= (calm_left != 0) ? 0 : pick_gap();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver, plus shared calm stretches with no idling
  always @(negedge clk) begin
    if (calm_left != 0) begin
      calm_left <= calm_left - 1;
    end else if ($urandom_range(0, 199) == 0) begin
      calm_left <= $urandom_range(40, 150);
    end
    if (stall_left != 0) begin
      rsp_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp_ready <= 1'b1;
      if (calm_left == 0) stall_left <= pick_gap();
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      req_fire = req_valid && req_ready;
      if (req_fire) begin
        expected_distances.push_back(predict_distance(req));
        accepted_count++;
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_distances.size() == 0) begin
          report_mismatch("beat with none pending", rsp.day_distance, 0);
        end else begin
          expected_beat = expected_distances.pop_front();
          if (rsp.day_distance !== expected_beat.day_distance)
            report_mismatch("day_distance", rsp.day_distance, expected_beat.day_distance);
          if (rsp.range_error !== expected_beat.range_error)
            report_mismatch("range_error", rsp.range_error, expected_beat.range_error);
        end
      end
      if (req_fire || (rsp_valid && rsp_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("FAIL gregorian_date_difference");
          $finish;
        end
      end
    end
  end

  initial begin
    // directed: range ends, leap rules, overflow days, errors in each field
    queue_pair(make_pair(1, 1, 1, 1, 1, 1), 1'b0);
    queue_pair(make_pair(1, 1, 1, 31, 12, 9999), 1'b0);
    queue_pair(make_pair(31, 12, 9999, 1, 1, 1), 1'b0);
    queue_pair(make_pair(1, 1, 1, 31, 12, YEAR_TOP), 1'b0);
    queue_pair(make_pair(1, 12, 12000, 1, 1, 1), 1'b0);
    queue_pair(make_pair(28, 2, 2000, 1, 3, 2000), 1'b0);
    queue_pair(make_pair(1, 3, 2000, 28, 2, 2000), 1'b0);
    queue_pair(make_pair(28, 2, 1900, 1, 3, 1900), 1'b0);
    queue_pair(make_pair(28, 2, 2024, 1, 3, 2024), 1'b0);
    queue_pair(make_pair(28, 2, 2023, 1, 3, 2023), 1'b0);
    queue_pair(make_pair(31, 2, 2023, 3, 3, 2023), 1'b0);
    queue_pair(make_pair(31, 11, 2023, 1, 12, 2023), 1'b0);
    queue_pair(make_pair(31, 12, YEAR_TOP, 31, 12, YEAR_TOP), 1'b0);
    queue_pair(make_pair(1, 0, 2000, 1, 1, 2000), 1'b0);
    queue_pair(make_pair(1, 1, 2000, 1, 13, 2000), 1'b0);
    queue_pair(make_pair(1, 15, 2000, 1, 1, 2000), 1'b0);
    queue_pair(make_pair(1, 1, 2000, 0, 1, 2000), 1'b0);
    queue_pair(make_pair(0, 6, 2000, 1, 1, 2000), 1'b0);
    queue_pair(make_pair(1, 1, 0, 1, 1, 2000), 1'b0);
    queue_pair(make_pair(1, 1, 2000, 1, 1, 0), 1'b0);
    queue_pair(make_pair(0, 0, 0, 0, 0, 0), 1'b0);
    queue_pair(make_pair(31, 15, YEAR_TOP, 31, 15, YEAR_TOP), 1'b0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      queue_pair(random_pair(), (i % DRAIN_EVERY) == 0);
    end
    total_items = pending_dates.size();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (accepted_count != total_items || expected_distances.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS gregorian_date_difference");
    end else begin
      $display("FAIL gregorian_date_difference");
    end
    $finish;
  end

endmodule

// File: gregorian_date_difference.f
+incdir+sv
sv/gdd_pkg.sv
sv/gdd_lane.sv
sv/gdd_merge.sv
sv/gregorian_date_difference.sv
tb/gregorian_date_difference_test.sv
